// ===== rtl/core/lfu_pkg.sv =====
package lfu_pkg;

    // default geometry
    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 64;
    localparam int DEF_COUNT_BITS = 16;

    // capacity register
    localparam int               CAP_BITS  = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // operation codes
    typedef enum logic [1:0] {
        ACT_PUT    = 2'd0,
        ACT_GET    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    // result status codes
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_MISS = 1'b1;

    // slot update commands broadcast to the cell row
    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_FILL,
        UPD_BUMP,
        UPD_FREE,
        UPD_CLEAR
    } t_upd_op;

    // flags of the search token that walks down the cell row
    typedef struct packed {
        logic live;
        logic hit;
        logic free_seen;
        logic min_seen;
    } t_scan;

endpackage

// ===== rtl/core/lfu_cell.sv =====
module lfu_cell
    import lfu_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int SLOT       = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [KEY_BITS-1:0]         i_key,
    input  logic [VALUE_BITS-1:0]       i_value,
    input  t_upd_op                     i_upd_op,
    input  logic [$clog2(ENTRIES)-1:0]  i_upd_idx,
    input  t_scan                       i_scan,
    input  logic [$clog2(ENTRIES)-1:0]  i_hit_idx,
    input  logic [VALUE_BITS-1:0]       i_hit_value,
    input  logic [$clog2(ENTRIES)-1:0]  i_free_idx,
    input  logic [$clog2(ENTRIES)-1:0]  i_min_idx,
    input  logic [COUNT_BITS-1:0]       i_min_count,
    input  logic [KEY_BITS-1:0]         i_min_key,
    output t_scan                       o_scan,
    output logic [$clog2(ENTRIES)-1:0]  o_hit_idx,
    output logic [VALUE_BITS-1:0]       o_hit_value,
    output logic [$clog2(ENTRIES)-1:0]  o_free_idx,
    output logic [$clog2(ENTRIES)-1:0]  o_min_idx,
    output logic [COUNT_BITS-1:0]       o_min_count,
    output logic [KEY_BITS-1:0]         o_min_key
);

    localparam int                  IDX_BITS = $clog2(ENTRIES);
    localparam logic [IDX_BITS-1:0] MY_IDX   = IDX_BITS'(SLOT);

    // slot contents
    logic                  r_valid;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [COUNT_BITS-1:0] r_count;

    // token registers toward the next cell
    t_scan                 r_scan,      n_scan;
    logic [IDX_BITS-1:0]   r_hit_idx,   n_hit_idx;
    logic [VALUE_BITS-1:0] r_hit_value, n_hit_value;
    logic [IDX_BITS-1:0]   r_free_idx,  n_free_idx;
    logic [IDX_BITS-1:0]   r_min_idx,   n_min_idx;
    logic [COUNT_BITS-1:0] r_min_count, n_min_count;
    logic [KEY_BITS-1:0]   r_min_key,   n_min_key;

    logic my_hit;
    logic my_sel;

    assign my_hit = r_valid && (r_key == i_key);
    assign my_sel = (i_upd_idx == MY_IDX);

    always_comb begin
        n_scan      = i_scan;
        n_hit_idx   = i_hit_idx;
        n_hit_value = i_hit_value;
        n_free_idx  = i_free_idx;
        n_min_idx   = i_min_idx;
        n_min_count = i_min_count;
        n_min_key   = i_min_key;
        if (!i_scan.hit && my_hit) begin
            n_scan.hit  = 1'b1;
            n_hit_idx   = MY_IDX;
            n_hit_value = r_value;
        end
        if (!i_scan.free_seen && !r_valid) begin
            n_scan.free_seen = 1'b1;
            n_free_idx       = MY_IDX;
        end
        // strict less keeps the lowest slot on a tie
        if (r_valid && (!i_scan.min_seen || (r_count < i_min_count))) begin
            n_scan.min_seen = 1'b1;
            n_min_idx       = MY_IDX;
            n_min_count     = r_count;
            n_min_key       = r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
            r_scan  <= '0;
        end else begin
            r_scan <= n_scan;
            if (i_upd_op == UPD_CLEAR) begin
                r_valid <= 1'b0;
                r_count <= '0;
            end else if (my_sel) begin
                case (i_upd_op)
                    UPD_FILL: begin
                        r_valid <= 1'b1;
                        r_count <= COUNT_BITS'(1);
                    end
                    UPD_BUMP: begin
                        if (r_count != '1) begin
                            r_count <= r_count + COUNT_BITS'(1);
                        end
                    end
                    UPD_FREE: begin
                        r_valid <= 1'b0;
                        r_count <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_hit_idx   <= n_hit_idx;
        r_hit_value <= n_hit_value;
        r_free_idx  <= n_free_idx;
        r_min_idx   <= n_min_idx;
        r_min_count <= n_min_count;
        r_min_key   <= n_min_key;
        if (my_sel && (i_upd_op == UPD_FILL)) begin
            r_key   <= i_key;
            r_value <= i_value;
        end else if (my_sel && (i_upd_op == UPD_BUMP)) begin
            r_value <= i_value;
        end
    end

    assign o_scan      = r_scan;
    assign o_hit_idx   = r_hit_idx;
    assign o_hit_value = r_hit_value;
    assign o_free_idx  = r_free_idx;
    assign o_min_idx   = r_min_idx;
    assign o_min_count = r_min_count;
    assign o_min_key   = r_min_key;

endmodule

// ===== rtl/core/lfu_cache_table.sv =====
// channel      | direction | handshake                       | payload
// -------------+-----------+---------------------------------+------------------------------
// operation    | in        | start high while busy low       | i_action, i_key, i_value_in
// result       | out       | o_done strobe, one cycle        | o_status, o_value_out,
//              |           |                                 | o_evicted, o_evicted_key,
//              |           |                                 | o_occupancy
// capacity cfg | in        | i_cfg_valid and o_cfg_ready     | i_cfg_data
//
// an operation runs from start to the o_done strobe as follows: the operation is captured,
// then the search token walks the cell row through each slot's token register in turn,
// then the decision and slot update are made and the result is registered; the walk grows with the row length
// busy is high from acceptance until the strobe, so a new start is taken in the cycle that
// shows the result
// reset (i_rst_n low at a clock edge) empties every slot and sets capacity to 16
// results are never held off: each is valid in the o_done cycle and stays until the next result
module lfu_cache_table
    import lfu_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // operation transaction
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_action,
    input  logic [KEY_BITS-1:0]            i_key,
    input  logic [VALUE_BITS-1:0]          i_value_in,
    // result transaction
    output logic                           o_done,
    output logic                           o_status,
    output logic [VALUE_BITS-1:0]          o_value_out,
    output logic                           o_evicted,
    output logic [KEY_BITS-1:0]            o_evicted_key,
    output logic [$clog2(ENTRIES+1)-1:0]   o_occupancy,
    // capacity register write
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [CAP_BITS-1:0]            i_cfg_data
);

    localparam int IDX_BITS = $clog2(ENTRIES);
    localparam int OCC_BITS = $clog2(ENTRIES + 1);
    localparam int CMP_BITS = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;

    // captured operation
    logic                  r_busy;
    logic                  r_inject;
    t_action               r_action;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    // capacity register and running count of valid slots
    logic [CAP_BITS-1:0]   r_cap;
    logic [OCC_BITS-1:0]   r_occ, n_occ;

    // result registers
    logic                  r_done;
    logic                  r_status,      n_status;
    logic [VALUE_BITS-1:0] r_value_out,   n_value_out;
    logic                  r_evicted,     n_evicted;
    logic [KEY_BITS-1:0]   r_evicted_key, n_evicted_key;

    // token chain between cells; element 0 is fed here, element ENTRIES returns
    t_scan                 scan      [ENTRIES+1];
    logic [IDX_BITS-1:0]   hit_idx   [ENTRIES+1];
    logic [VALUE_BITS-1:0] hit_value [ENTRIES+1];
    logic [IDX_BITS-1:0]   free_idx  [ENTRIES+1];
    logic [IDX_BITS-1:0]   min_idx   [ENTRIES+1];
    logic [COUNT_BITS-1:0] min_count [ENTRIES+1];
    logic [KEY_BITS-1:0]   min_key   [ENTRIES+1];

    // update broadcast
    t_upd_op               upd_op;
    logic [IDX_BITS-1:0]   upd_idx;

    logic                  accept;
    logic                  finish;
    t_scan                 tail;
    logic [CMP_BITS-1:0]   eff_cap;
    logic [CMP_BITS-1:0]   occ_ext;

    assign accept      = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;

    // a fresh token enters the row the cycle after capture, against the held key
    assign scan[0]      = '{live: r_inject, hit: 1'b0, free_seen: 1'b0, min_seen: 1'b0};
    assign hit_idx[0]   = '0;
    assign hit_value[0] = '0;
    assign free_idx[0]  = '0;
    assign min_idx[0]   = '0;
    assign min_count[0] = '0;
    assign min_key[0]   = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lfu_cell #(
            .ENTRIES    (ENTRIES),
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .COUNT_BITS (COUNT_BITS),
            .SLOT       (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_key       (r_key),
            .i_value     (r_value),
            .i_upd_op    (upd_op),
            .i_upd_idx   (upd_idx),
            .i_scan      (scan[g]),
            .i_hit_idx   (hit_idx[g]),
            .i_hit_value (hit_value[g]),
            .i_free_idx  (free_idx[g]),
            .i_min_idx   (min_idx[g]),
            .i_min_count (min_count[g]),
            .i_min_key   (min_key[g]),
            .o_scan      (scan[g+1]),
            .o_hit_idx   (hit_idx[g+1]),
            .o_hit_value (hit_value[g+1]),
            .o_free_idx  (free_idx[g+1]),
            .o_min_idx   (min_idx[g+1]),
            .o_min_count (min_count[g+1]),
            .o_min_key   (min_key[g+1])
        );
    end

    assign tail   = scan[ENTRIES];
    assign finish = tail.live;

    // zero capacity acts as one, anything above the row length as the full row
    always_comb begin
        eff_cap = CMP_BITS'(r_cap);
        if (eff_cap == '0) begin
            eff_cap = CMP_BITS'(1);
        end else if (eff_cap > CMP_BITS'(ENTRIES)) begin
            eff_cap = CMP_BITS'(ENTRIES);
        end
    end
    assign occ_ext = CMP_BITS'(r_occ);

    // decision once the token has seen every slot
    always_comb begin
        upd_op        = UPD_NONE;
        upd_idx       = '0;
        n_occ         = r_occ;
        n_status      = STAT_OK;
        n_value_out   = '0;
        n_evicted     = 1'b0;
        n_evicted_key = '0;
        if (finish) begin
            case (r_action)
                ACT_PUT: begin
                    if (tail.hit) begin
                        upd_op  = UPD_BUMP;
                        upd_idx = hit_idx[ENTRIES];
                    end else if (tail.free_seen && (occ_ext < eff_cap)) begin
                        upd_op  = UPD_FILL;
                        upd_idx = free_idx[ENTRIES];
                        n_occ   = r_occ + OCC_BITS'(1);
                    end else if (tail.min_seen) begin
                        // full: replace the least used entry, lowest slot on a tie
                        upd_op        = UPD_FILL;
                        upd_idx       = min_idx[ENTRIES];
                        n_evicted     = 1'b1;
                        n_evicted_key = min_key[ENTRIES];
                    end
                end
                ACT_GET: begin
                    if (tail.hit) begin
                        n_value_out = hit_value[ENTRIES];
                    end else begin
                        n_status = STAT_MISS;
                    end
                end
                ACT_REMOVE: begin
                    if (tail.hit) begin
                        upd_op  = UPD_FREE;
                        upd_idx = hit_idx[ENTRIES];
                        n_occ   = r_occ - OCC_BITS'(1);
                    end else begin
                        n_status = STAT_MISS;
                    end
                end
                ACT_CLEAR: begin
                    upd_op = UPD_CLEAR;
                    n_occ  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_inject <= 1'b0;
            r_done   <= 1'b0;
            r_occ    <= '0;
            r_cap    <= CAP_RESET;
        end else begin
            r_inject <= accept;
            r_done   <= finish;
            r_occ    <= n_occ;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (finish) begin
                r_busy <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    // operation capture and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= t_action'(i_action);
            r_key    <= i_key;
            r_value  <= i_value_in;
        end
        if (finish) begin
            r_status      <= n_status;
            r_value_out   <= n_value_out;
            r_evicted     <= n_evicted;
            r_evicted_key <= n_evicted_key;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_value_out   = r_value_out;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_evicted_key;
    assign o_occupancy   = r_occ;

endmodule
